// ===== design/onewire_temp_read_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the one-wire temperature read sequencer
// Short forms for clocked implications with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMP_READ_SEQUENCER_MACROS_SVH
`define ONEWIRE_TEMP_READ_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OWTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OWTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/owts_pkg.sv =====
// ----------------------------------------------------------------------------
// owts_pkg
// Types, codes and constants shared by the temperature read sequencer.
// ----------------------------------------------------------------------------
package owts_pkg;

  localparam int unsigned ScratchLen = 9;
  localparam int unsigned CntW       = $clog2(ScratchLen + 1);

  localparam logic [7:0] CMD_SKIP    = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READ    = 8'hBE;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  localparam logic signed [15:0] POWER_ON_RAW = 16'sh0550;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } bus_op_e;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_SAMPLE      = 3'd1,
    REG_CONV_WAIT   = 3'd2,
    REG_RETRY_WAIT  = 3'd3,
    REG_STALE_AFTER = 3'd4,
    REG_MIN_TEMP    = 3'd5,
    REG_MAX_TEMP    = 3'd6
  } cfg_idx_e;

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_CONV_RESET = 10'b00_0000_0010,
    ST_CONV_SKIP  = 10'b00_0000_0100,
    ST_CONV_CMD   = 10'b00_0000_1000,
    ST_CONV_WAIT  = 10'b00_0001_0000,
    ST_READ_RESET = 10'b00_0010_0000,
    ST_READ_SKIP  = 10'b00_0100_0000,
    ST_READ_CMD   = 10'b00_1000_0000,
    ST_READ_BYTES = 10'b01_0000_0000,
    ST_BACKOFF    = 10'b10_0000_0000
  } seq_state_e;

  typedef struct packed {
    logic               enable;
    logic [31:0]        sample_period_ms;
    logic [31:0]        conversion_wait_ms;
    logic [31:0]        retry_wait_ms;
    logic [31:0]        stale_after_ms;
    logic signed [11:0] min_temp_sixteenths;
    logic signed [11:0] max_temp_sixteenths;
  } cfg_t;

  typedef struct packed {
    bus_op_e            bus_op;
    logic [7:0]         write_value;
    logic [3:0]         phase;
    logic               temp_valid;
    logic signed [15:0] temperature;
    logic [31:0]        crc_error_count;
    logic [31:0]        bus_error_count;
  } res_t;

  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctl_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] value;
  } crc_sts_t;

  // Numeric phase as reported on the result stream.
  function automatic logic [3:0] phase_code(seq_state_e st);
    logic [3:0] code;
    code = 4'd0;
    unique case (st)
      ST_IDLE:       code = 4'd0;
      ST_CONV_RESET: code = 4'd1;
      ST_CONV_SKIP:  code = 4'd2;
      ST_CONV_CMD:   code = 4'd3;
      ST_CONV_WAIT:  code = 4'd4;
      ST_READ_RESET: code = 4'd5;
      ST_READ_SKIP:  code = 4'd6;
      ST_READ_CMD:   code = 4'd7;
      ST_READ_BYTES: code = 4'd8;
      ST_BACKOFF:    code = 4'd9;
      default:       code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== design/owts_crc.sv =====
// ----------------------------------------------------------------------------
// owts_crc
// Bit-serial reflected CRC-8, one data bit per clock cycle.
// ----------------------------------------------------------------------------
module owts_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  owts_pkg::crc_ctl_t ctl_i,
  output owts_pkg::crc_sts_t sts_o
);
  import owts_pkg::*;

  logic [7:0] crc_q, crc_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] bit_q, bit_d;
  logic       busy_q, busy_d;
  logic       mix;

  always_comb begin
    crc_d   = crc_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    busy_d  = busy_q;
    mix     = crc_q[0] ^ shift_q[0];
    if (ctl_i.clear) begin
      crc_d = 8'h00;
    end else if (ctl_i.start) begin
      shift_d = ctl_i.data;
      bit_d   = 3'd0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      crc_d   = {1'b0, crc_q[7:1]} ^ (mix ? CRC_POLY : 8'h00);
      shift_d = {1'b0, shift_q[7:1]};
      bit_d   = bit_q + 3'd1;
      if (bit_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= 8'h00;
      bit_q  <= 3'd0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      bit_q  <= bit_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.value = crc_q;

endmodule

// ===== design/owts_seq.sv =====
// ----------------------------------------------------------------------------
// owts_seq
// Measurement sequencer: timers, bus commands, scratchpad check, counters.
// ----------------------------------------------------------------------------
`include "onewire_temp_read_sequencer_macros.svh"

module owts_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [31:0]    now_ms_i,
  input  logic           presence_i,
  input  logic [7:0]     read_value_i,
  input  owts_pkg::cfg_t cfg_i,
  output logic           busy_o,
  output owts_pkg::res_t res_o
);
  import owts_pkg::*;

  localparam logic [CntW-1:0] LastIdx = CntW'(ScratchLen - 1);

  seq_state_e         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [31:0]        cycle_start_q, cycle_start_d;
  logic [31:0]        conv_start_q, conv_start_d;
  logic [31:0]        backoff_q, backoff_d;
  logic [31:0]        last_good_q, last_good_d;
  logic               have_q, have_d;
  logic signed [15:0] temp_q, temp_d;
  logic [31:0]        crc_err_q, crc_err_d;
  logic [31:0]        bus_err_q, bus_err_d;
  logic [7:0]         scr_lo_q, scr_lo_d;
  logic [7:0]         scr_hi_q, scr_hi_d;

  bus_op_e            op;
  logic [7:0]         wv;
  crc_ctl_t           crc_ctl;
  crc_sts_t           crc_sts;
  logic signed [15:0] raw;
  logic signed [15:0] min16;
  logic signed [15:0] max16;
  logic               in_range;
  logic               power_on;

  owts_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .sts_o  (crc_sts)
  );

  assign raw      = {scr_hi_q, scr_lo_q};
  assign min16    = {{4{cfg_i.min_temp_sixteenths[11]}}, cfg_i.min_temp_sixteenths};
  assign max16    = {{4{cfg_i.max_temp_sixteenths[11]}}, cfg_i.max_temp_sixteenths};
  assign in_range = (raw >= min16) && (raw <= max16);
  assign power_on = (raw == POWER_ON_RAW) && !have_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cycle_start_d = cycle_start_q;
    conv_start_d  = conv_start_q;
    backoff_d     = backoff_q;
    last_good_d   = last_good_q;
    have_d        = have_q;
    temp_d        = temp_q;
    crc_err_d     = crc_err_q;
    bus_err_d     = bus_err_q;
    scr_lo_d      = scr_lo_q;
    scr_hi_d      = scr_hi_q;
    op            = OP_NONE;
    wv            = 8'h00;
    crc_ctl       = '0;

    if (step_i && cfg_i.enable) begin
      unique case (state_q) inside
        ST_IDLE: begin
          if ((now_ms_i - cycle_start_q) >= cfg_i.sample_period_ms) begin
            cycle_start_d = now_ms_i;
            state_d       = ST_CONV_RESET;
          end
        end
        ST_CONV_RESET, ST_READ_RESET: begin
          op = OP_RESET;
          if (presence_i) begin
            state_d = (state_q == ST_CONV_RESET) ? ST_CONV_SKIP : ST_READ_SKIP;
          end else begin
            bus_err_d = bus_err_q + 32'd1;
            backoff_d = now_ms_i;
            state_d   = ST_BACKOFF;
          end
        end
        ST_CONV_SKIP, ST_READ_SKIP: begin
          op      = OP_WRITE;
          wv      = CMD_SKIP;
          state_d = (state_q == ST_CONV_SKIP) ? ST_CONV_CMD : ST_READ_CMD;
        end
        ST_CONV_CMD: begin
          op           = OP_WRITE;
          wv           = CMD_CONVERT;
          conv_start_d = now_ms_i;
          state_d      = ST_CONV_WAIT;
        end
        ST_CONV_WAIT: begin
          if ((now_ms_i - conv_start_q) >= cfg_i.conversion_wait_ms) begin
            state_d = ST_READ_RESET;
          end
        end
        ST_READ_CMD: begin
          op            = OP_WRITE;
          wv            = CMD_READ;
          cnt_d         = '0;
          crc_ctl.clear = 1'b1;
          state_d       = ST_READ_BYTES;
        end
        ST_READ_BYTES: begin
          op    = OP_READ;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == '0) begin
            scr_lo_d = read_value_i;
          end
          if (cnt_q == CntW'(1)) begin
            scr_hi_d = read_value_i;
          end
          if (cnt_q == LastIdx) begin
            // The last byte carries the check value for all earlier bytes.
            state_d = ST_IDLE;
            if (crc_sts.value != read_value_i) begin
              crc_err_d = crc_err_q + 32'd1;
            end else if (!power_on && in_range) begin
              temp_d      = raw;
              have_d      = 1'b1;
              last_good_d = now_ms_i;
            end
          end else begin
            crc_ctl.start = 1'b1;
            crc_ctl.data  = read_value_i;
          end
        end
        ST_BACKOFF: begin
          if ((now_ms_i - backoff_q) >= cfg_i.retry_wait_ms) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_o.bus_op          = op;
    res_o.write_value     = wv;
    res_o.phase           = phase_code(state_d);
    res_o.temp_valid      = have_d && ((now_ms_i - last_good_d) <= cfg_i.stale_after_ms);
    res_o.temperature     = temp_d;
    res_o.crc_error_count = crc_err_d;
    res_o.bus_error_count = bus_err_d;
  end

  assign busy_o = crc_sts.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      cycle_start_q <= 32'd0;
      conv_start_q  <= 32'd0;
      backoff_q     <= 32'd0;
      last_good_q   <= 32'd0;
      have_q        <= 1'b0;
      temp_q        <= 16'sd0;
      crc_err_q     <= 32'd0;
      bus_err_q     <= 32'd0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      cycle_start_q <= cycle_start_d;
      conv_start_q  <= conv_start_d;
      backoff_q     <= backoff_d;
      last_good_q   <= last_good_d;
      have_q        <= have_d;
      temp_q        <= temp_d;
      crc_err_q     <= crc_err_d;
      bus_err_q     <= bus_err_d;
    end
  end

  // Scratchpad bytes are always written before they are used.
  always_ff @(posedge clk_i) begin
    scr_lo_q <= scr_lo_d;
    scr_hi_q <= scr_hi_d;
  end

  `OWTS_ASSERT_SAME(a_no_step_while_crc_busy, step_i, !crc_sts.busy)
  `OWTS_ASSERT_SAME(a_byte_count_in_range, state_q == ST_READ_BYTES, cnt_q <= LastIdx)
  `OWTS_ASSERT_SAME(a_crc_start_only_reading, crc_ctl.start, state_q == ST_READ_BYTES)
  `OWTS_ASSERT_NEXT(a_bus_err_only_on_step, !step_i, $stable(bus_err_q))

endmodule

// ===== design/onewire_temp_read_sequencer.sv =====
// Each result item is registered when its input item is accepted.
// Throughput: one item per cycle while output is not stalled, except scratchpad
// bytes before the last, which stall the next item while the bit-serial CRC runs.
// Reset: sequencer idle, timers and error counters zero, no reading held, the
// configuration registers at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// onewire_temp_read_sequencer
// Top level: stream ports, configuration registers and the result register.
// ----------------------------------------------------------------------------
module onewire_temp_read_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_ms[31:0], presence[32], read_value[40:33], zero fill [47:41]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_op[1:0], write_value[9:2], phase[13:10], temp_valid[14],
  // temperature[30:15], crc_error_count[62:31], bus_error_count[94:63], zero [95]
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);
  import owts_pkg::*;

  cfg_t  cfg_q, cfg_d;
  res_t  res;
  res_t  res_q;
  logic  m_valid_q, m_valid_d;
  logic  busy;
  logic  step;

  assign s_axis_tready = !busy && (!m_valid_q || m_axis_tready);
  assign step          = s_axis_tvalid && s_axis_tready;

  owts_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .now_ms_i     (s_axis_tdata[31:0]),
    .presence_i   (s_axis_tdata[32]),
    .read_value_i (s_axis_tdata[40:33]),
    .cfg_i        (cfg_q),
    .busy_o       (busy),
    .res_o        (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ENABLE:      cfg_d.enable              = cfg_wdata_i[0];
        REG_SAMPLE:      cfg_d.sample_period_ms    = cfg_wdata_i;
        REG_CONV_WAIT:   cfg_d.conversion_wait_ms  = cfg_wdata_i;
        REG_RETRY_WAIT:  cfg_d.retry_wait_ms       = cfg_wdata_i;
        REG_STALE_AFTER: cfg_d.stale_after_ms      = cfg_wdata_i;
        REG_MIN_TEMP:    cfg_d.min_temp_sixteenths = cfg_wdata_i[11:0];
        REG_MAX_TEMP:    cfg_d.max_temp_sixteenths = cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (step) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable              <= 1'b1;
      cfg_q.sample_period_ms    <= 32'd2000;
      cfg_q.conversion_wait_ms  <= 32'd750;
      cfg_q.retry_wait_ms       <= 32'd1000;
      cfg_q.stale_after_ms      <= 32'd10000;
      cfg_q.min_temp_sixteenths <= -12'sd880;
      cfg_q.max_temp_sixteenths <= 12'sd2000;
      m_valid_q                 <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.bus_error_count, res_q.crc_error_count,
                          res_q.temperature, res_q.temp_valid, res_q.phase,
                          res_q.write_value, res_q.bus_op};

endmodule

// ===== tb/onewire_temp_read_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temp_read_sequencer_test
// Drives scheduler steps into the temperature read sequencer and checks every
// result item against a cycle-free prediction of the sequence: bus operations,
// phase, held temperature, validity and both error counters. A short directed
// run under the reset settings is followed by random steps under several
// register settings, with random idling on both streams and one long output
// stall.
// ----------------------------------------------------------------------------
module onewire_temp_read_sequencer_test;
  import owts_pkg::*;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_CONV_RESET = 4'd1;
  localparam logic [3:0] PH_CONV_SKIP  = 4'd2;
  localparam logic [3:0] PH_CONV_CMD   = 4'd3;
  localparam logic [3:0] PH_CONV_WAIT  = 4'd4;
  localparam logic [3:0] PH_READ_RESET = 4'd5;
  localparam logic [3:0] PH_READ_SKIP  = 4'd6;
  localparam logic [3:0] PH_READ_CMD   = 4'd7;
  localparam logic [3:0] PH_READ_BYTES = 4'd8;
  localparam logic [3:0] PH_BACKOFF    = 4'd9;

  // Register index that the block has no register for.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 500;

  typedef logic [ScratchLen-1:0][7:0] pad_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        presence;
    logic [7:0]  read_value;
  } bus_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    pad_t        scratch;
    logic [4:0]  byte_count;
    logic [31:0] cycle_start_ms;
    logic [31:0] conv_start_ms;
    logic [31:0] backoff_start_ms;
    logic [31:0] last_good_ms;
    logic        have_reading;
    logic [15:0] temp_held;
    logic [31:0] crc_errors;
    logic [31:0] bus_errors;
  } sensor_ctx_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  cfg_t        cfg_cur;
  sensor_ctx_t model_ctx;
  sensor_ctx_t gen_ctx;
  pad_t        gen_pad;
  logic [31:0] gen_now;
  bus_item_t   pending_steps[$];
  bus_item_t   offered;
  res_t        due_results[$];
  int          idle_pct = 33;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  int          fail_count = 0;

  onewire_temp_read_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Reflected CRC-8 over every scratchpad byte but the last.
  function automatic logic [7:0] scratch_crc(input pad_t pad);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = '0;
    for (int i = 0; i < ScratchLen - 1; i++) begin
      b = pad[i];
      for (int k = 0; k < 8; k++) begin
        mix = crc[0] ^ b[0];
        crc = crc >> 1;
        if (mix) crc = crc ^ CRC_POLY;
        b = b >> 1;
      end
    end
    return crc;
  endfunction

  // One scheduler step: advances the sequence and forms the result item.
  task automatic sensor_step(inout sensor_ctx_t c, input bus_item_t it, output res_t r);
    logic [31:0]        elapsed;
    logic signed [15:0] raw;
    r = '0;
    r.bus_op = OP_NONE;
    if (cfg_cur.enable) begin
      case (c.phase)
        PH_IDLE: begin
          elapsed = it.now_ms - c.cycle_start_ms;
          if (elapsed >= cfg_cur.sample_period_ms) begin
            c.cycle_start_ms = it.now_ms;
            c.phase = PH_CONV_RESET;
          end
        end
        PH_CONV_RESET, PH_READ_RESET: begin
          r.bus_op = OP_RESET;
          if (it.presence) begin
            c.phase = (c.phase == PH_CONV_RESET) ? PH_CONV_SKIP : PH_READ_SKIP;
          end else begin
            c.bus_errors = c.bus_errors + 32'd1;
            c.backoff_start_ms = it.now_ms;
            c.phase = PH_BACKOFF;
          end
        end
        PH_CONV_SKIP: begin
          r.bus_op = OP_WRITE;
          r.write_value = CMD_SKIP;
          c.phase = PH_CONV_CMD;
        end
        PH_CONV_CMD: begin
          r.bus_op = OP_WRITE;
          r.write_value = CMD_CONVERT;
          c.conv_start_ms = it.now_ms;
          c.phase = PH_CONV_WAIT;
        end
        PH_CONV_WAIT: begin
          elapsed = it.now_ms - c.conv_start_ms;
          if (elapsed >= cfg_cur.conversion_wait_ms) c.phase = PH_READ_RESET;
        end
        PH_READ_SKIP: begin
          r.bus_op = OP_WRITE;
          r.write_value = CMD_SKIP;
          c.phase = PH_READ_CMD;
        end
        PH_READ_CMD: begin
          r.bus_op = OP_WRITE;
          r.write_value = CMD_READ;
          c.byte_count = '0;
          c.phase = PH_READ_BYTES;
        end
        PH_READ_BYTES: begin
          r.bus_op = OP_READ;
          c.scratch[c.byte_count] = it.read_value;
          c.byte_count = c.byte_count + 5'd1;
          if (c.byte_count >= ScratchLen) begin
            c.phase = PH_IDLE;
            if (scratch_crc(c.scratch) != c.scratch[ScratchLen-1]) begin
              c.crc_errors = c.crc_errors + 32'd1;
            end else begin
              raw = {c.scratch[1], c.scratch[0]};
              // The power-on value only counts once a good reading exists.
              if (!(raw == POWER_ON_RAW && !c.have_reading) &&
                  raw >= $signed(cfg_cur.min_temp_sixteenths) &&
                  raw <= $signed(cfg_cur.max_temp_sixteenths)) begin
                c.temp_held = raw;
                c.have_reading = 1'b1;
                c.last_good_ms = it.now_ms;
              end
            end
          end
        end
        PH_BACKOFF: begin
          elapsed = it.now_ms - c.backoff_start_ms;
          if (elapsed >= cfg_cur.retry_wait_ms) c.phase = PH_IDLE;
        end
        default: c.phase = PH_IDLE;
      endcase
    end
    elapsed = it.now_ms - c.last_good_ms;
    r.write_value = r.write_value;
    r.phase = c.phase;
    r.temp_valid = c.have_reading && (elapsed <= cfg_cur.stale_after_ms);
    r.temperature = c.temp_held;
    r.crc_error_count = c.crc_errors;
    r.bus_error_count = c.bus_errors;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  // Driver: offers queued steps and predicts the result of each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sensor_step(model_ctx, offered, want);
        due_results.push_back(want);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_steps.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered = pending_steps.pop_front();
          s_axis_tdata <= {7'b0, offered.read_value, offered.presence, offered.now_ms};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result items and paces the receiving side.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          fail_count++;
          $error("result item with none expected");
        end else begin
          want = due_results.pop_front();
          check_field("bus_op", 32'(want.bus_op), 32'(m_axis_tdata[1:0]));
          check_field("write_value", 32'(want.write_value), 32'(m_axis_tdata[9:2]));
          check_field("phase", 32'(want.phase), 32'(m_axis_tdata[13:10]));
          check_field("temp_valid", 32'(want.temp_valid), 32'(m_axis_tdata[14]));
          check_field("temperature", {16'b0, want.temperature},
                      {16'b0, m_axis_tdata[30:15]});
          check_field("crc_error_count", want.crc_error_count, m_axis_tdata[62:31]);
          check_field("bus_error_count", want.bus_error_count, m_axis_tdata[94:63]);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held_once && results_seen >= HoldAfter) begin
        // One long stall so that the block backs up into its input.
        held_once = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic add_item(input logic [31:0] now, input logic pres, input logic [7:0] rd);
    bus_item_t it;
    res_t      unused;
    it.now_ms = now;
    it.presence = pres;
    it.read_value = rd;
    pending_steps.push_back(it);
    sensor_step(gen_ctx, it, unused);
  endtask

  // Plans the scratchpad for the read that is about to start.
  task automatic plan_pad();
    int lo;
    int hi;
    int raw;
    lo = int'(cfg_cur.min_temp_sixteenths);
    hi = int'(cfg_cur.max_temp_sixteenths);
    if (lo > hi) begin
      lo = -880;
      hi = 2000;
    end
    case ($urandom_range(9))
      4: raw = lo;
      5: raw = hi;
      6: raw = POWER_ON_RAW;
      7: raw = $urandom_range(1) ? lo - 1 : hi + 1;
      8: raw = $urandom_range(65535);
      9: raw = $urandom_range(1) ? -880 : 2000;
      default: raw = lo + $urandom_range(hi - lo);
    endcase
    for (int i = 2; i < ScratchLen - 1; i++) gen_pad[i] = 8'($urandom);
    gen_pad[0] = raw[7:0];
    gen_pad[1] = raw[15:8];
    gen_pad[ScratchLen-1] = scratch_crc(gen_pad);
    if ($urandom_range(99) < 15) gen_pad[ScratchLen-1] ^= 8'($urandom_range(1, 255));
    // Now and then a read of pure noise.
    if ($urandom_range(99) < 5) for (int i = 0; i < ScratchLen; i++) gen_pad[i] = 8'($urandom);
  endtask

  task automatic add_random_items(input int n);
    int          pick;
    logic        pres;
    logic [7:0]  rd;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3) gen_now = $urandom;
      else if (pick < 7) gen_now = gen_now + $urandom_range(20, 400);
      else gen_now = gen_now + $urandom_range(0, 4);
      if (gen_ctx.phase == PH_CONV_RESET || gen_ctx.phase == PH_READ_RESET)
        pres = ($urandom_range(99) < 90);
      else
        pres = 1'($urandom_range(1));
      if (gen_ctx.phase == PH_READ_CMD) plan_pad();
      if (gen_ctx.phase == PH_READ_BYTES) rd = gen_pad[gen_ctx.byte_count];
      else rd = 8'($urandom);
      add_item(gen_now, pres, rd);
    end
  endtask

  task automatic drain();
    while (pending_steps.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= value;
    case (addr)
      REG_ENABLE:      cfg_cur.enable = value[0];
      REG_SAMPLE:      cfg_cur.sample_period_ms = value;
      REG_CONV_WAIT:   cfg_cur.conversion_wait_ms = value;
      REG_RETRY_WAIT:  cfg_cur.retry_wait_ms = value;
      REG_STALE_AFTER: cfg_cur.stale_after_ms = value;
      REG_MIN_TEMP:    cfg_cur.min_temp_sixteenths = value[11:0];
      REG_MAX_TEMP:    cfg_cur.max_temp_sixteenths = value[11:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic en, input logic [31:0] sample,
                                input logic [31:0] conv, input logic [31:0] retry,
                                input logic [31:0] stale, input int lo, input int hi);
    write_reg(REG_ENABLE, {31'b0, en});
    write_reg(REG_SAMPLE, sample);
    write_reg(REG_CONV_WAIT, conv);
    write_reg(REG_RETRY_WAIT, retry);
    write_reg(REG_STALE_AFTER, stale);
    write_reg(REG_MIN_TEMP, lo);
    write_reg(REG_MAX_TEMP, hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    pad_t pad;
    int   lo;
    int   hi;
    int   t;
    cfg_cur = '{enable: 1'b1, sample_period_ms: 32'd2000, conversion_wait_ms: 32'd750,
                retry_wait_ms: 32'd1000, stale_after_ms: 32'd10000,
                min_temp_sixteenths: -12'sd880, max_temp_sixteenths: 12'sd2000};
    model_ctx = '0;
    gen_ctx = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a missing presence pulse and its back-off, then a full
    // measurement that returns the power-on value before any good reading.
    add_item(32'd0, 1'b1, 8'hA5);
    add_item(32'd2000, 1'b1, 8'h00);
    add_item(32'd2001, 1'b0, 8'hFF);
    add_item(32'd2500, 1'b1, 8'h5A);
    add_item(32'd3001, 1'b0, 8'h00);
    add_item(32'd4000, 1'b0, 8'hFF);
    add_item(32'd4001, 1'b1, 8'h00);
    add_item(32'd4002, 1'b0, 8'hFF);
    add_item(32'd4002, 1'b1, 8'h00);
    add_item(32'd4751, 1'b1, 8'h00);
    add_item(32'd4752, 1'b0, 8'h00);
    add_item(32'd4753, 1'b1, 8'h00);
    add_item(32'd4753, 1'b0, 8'h3C);
    add_item(32'd4754, 1'b0, 8'h00);
    pad = '1;
    pad[0] = POWER_ON_RAW[7:0];
    pad[1] = POWER_ON_RAW[15:8];
    pad[ScratchLen-1] = scratch_crc(pad);
    for (int i = 0; i < ScratchLen; i++) add_item(32'd4755 + i, 1'b0, pad[i]);
    add_item(32'hFFFF_FFFF, 1'b0, 8'h00);
    gen_now = 32'hFFFF_FFFF;
    drain();

    apply_settings(1'b1, 32'd6, 32'd3, 32'd5, 32'd40, -880, 2000);
    write_reg(REG_UNUSED, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    add_random_items(250);
    drain();

    apply_settings(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, -880, 2000);
    add_random_items(200);
    drain();

    // Largest waits, with the limits at their extremes the wrong way round.
    apply_settings(1'b1, '1, '1, '1, '1, 2000, -880);
    add_random_items(40);
    drain();

    apply_settings(1'b0, 32'd3, 32'd2, 32'd2, 32'd20, -880, 2000);
    add_random_items(60);
    drain();

    apply_settings(1'b1, 32'd4, 32'd2, 32'd3, 32'd25, 500, -100);
    add_random_items(150);
    drain();

    for (int p = 0; p < 5; p++) begin
      lo = $urandom_range(2880) - 880;
      hi = $urandom_range(2880) - 880;
      if (lo > hi && $urandom_range(99) < 80) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      idle_pct = (p == 2) ? 0 : 33;
      apply_settings(1'b1, $urandom_range(12), $urandom_range(8), $urandom_range(8),
                     $urandom_range(60), lo, hi);
      add_random_items(150);
      drain();
    end
    idle_pct = 33;

    apply_settings(1'b1, 32'd10, 32'd5, 32'd5, '1, -880, 2000);
    add_random_items(150);
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
